>>> rtl/core/rc4_pkg.sv
// Shared types, microcode encoding and control program for the RC4 engine.
// No dependencies; used by rc4_seq and rc4_stream_cipher_unit.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int KEY_BYTES_DEF = 16;
  localparam int KEY_SLOTS     = 16;
  localparam int KEY_SLOT_W    = 4;
  localparam int KEY_REG_W     = 64;
  localparam int SBOX_DEPTH    = 256;
  localparam int BYTE_W        = 8;
  localparam int STEP_W        = 4;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE    = 4'd0;
  localparam step_t ST_FILL    = 4'd1;
  localparam step_t ST_SCH0    = 4'd2;
  localparam step_t ST_SCH1    = 4'd3;
  localparam step_t ST_SCH2    = 4'd4;
  localparam step_t ST_SCH3    = 4'd5;
  localparam step_t ST_SCH_END = 4'd6;
  localparam step_t ST_CR0     = 4'd7;
  localparam step_t ST_CR1     = 4'd8;
  localparam step_t ST_CR2     = 4'd9;
  localparam step_t ST_CR3     = 4'd10;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef enum logic [2:0] {
    OP_NEXT,
    OP_DISPATCH,
    OP_LOOP,
    OP_EMIT,
    OP_GOTO
  } op_t;

  typedef enum logic [2:0] {
    RA_NONE,
    RA_N,
    RA_I_INC,
    RA_J_SUM,
    RA_KS
  } ra_t;

  typedef enum logic [1:0] {
    WA_NONE,
    WA_N,
    WA_I,
    WA_J
  } wa_t;

  typedef enum logic [1:0] {
    WD_N,
    WD_RD,
    WD_T
  } wd_t;

  typedef struct packed {
    op_t   op;
    step_t target;
    ra_t   ra;
    wa_t   wa;
    wd_t   wd;
    logic  ld_i;
    logic  ld_j;
    logic  key_en;
    logic  ld_t;
    logic  ld_sj;
    logic  clr_ij;
    logic  clr_k;
    logic  n_inc;
  } ucw_t;

  typedef struct packed {
    ucw_t cw;
    logic accept;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic action;
    logic n_last;
    logic out_free;
  } cond_t;

  localparam ucw_t UCW_NOP = '{
    op: OP_NEXT, target: ST_IDLE, ra: RA_NONE, wa: WA_NONE, wd: WD_N,
    ld_i: 1'b0, ld_j: 1'b0, key_en: 1'b0, ld_t: 1'b0, ld_sj: 1'b0,
    clr_ij: 1'b0, clr_k: 1'b0, n_inc: 1'b0
  };

  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    w = UCW_NOP;
    case (step)
      ST_IDLE: begin
        w.op = OP_DISPATCH;
      end
      ST_FILL: begin
        w.wa     = WA_N;
        w.wd     = WD_N;
        w.n_inc  = 1'b1;
        w.clr_ij = 1'b1;
        w.clr_k  = 1'b1;
        w.op     = OP_LOOP;
        w.target = ST_FILL;
      end
      ST_SCH0: begin
        w.ra = RA_N;
      end
      ST_SCH1: begin
        w.ra     = RA_J_SUM;
        w.ld_t   = 1'b1;
        w.ld_j   = 1'b1;
        w.key_en = 1'b1;
      end
      ST_SCH2: begin
        w.wa = WA_N;
        w.wd = WD_RD;
      end
      ST_SCH3: begin
        w.wa     = WA_J;
        w.wd     = WD_T;
        w.n_inc  = 1'b1;
        w.op     = OP_LOOP;
        w.target = ST_SCH0;
      end
      ST_SCH_END: begin
        w.clr_ij = 1'b1;
        w.op     = OP_GOTO;
        w.target = ST_IDLE;
      end
      ST_CR0: begin
        w.ra   = RA_I_INC;
        w.ld_i = 1'b1;
      end
      ST_CR1: begin
        w.ra   = RA_J_SUM;
        w.ld_t = 1'b1;
        w.ld_j = 1'b1;
      end
      ST_CR2: begin
        w.wa    = WA_I;
        w.wd    = WD_RD;
        w.ra    = RA_KS;
        w.ld_sj = 1'b1;
      end
      ST_CR3: begin
        w.wa     = WA_J;
        w.wd     = WD_T;
        w.op     = OP_EMIT;
        w.target = ST_IDLE;
      end
      default: begin
        w.op     = OP_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rc4_stream_cipher_unit.sv
// RC4 engine top level: ports, key registers, index datapath and output register.
// Depends on rc4_pkg, rc4_seq and rc4_ram.
`timescale 1ns / 1ps
`default_nettype none

// RC4 stream cipher. A beat with action 0 rekeys: the 256-byte state table is
// loaded with the identity and mixed with KEY_BYTES bytes of {key_high, key_low};
// it gives no result and does one fill write per entry, then four steps per
// swap through the single-read-port state RAM. A beat with action 1 XORs
// data_byte with the next keystream byte and gives one result beat, through a
// chain of dependent reads and writes on that RAM.
// end_of_message clears both indices after its byte; the table is kept.
// Crypt before the first rekey returns undefined data. Write the key registers
// only while the engine is idle.
module rc4_stream_cipher_unit
  import rc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 action,
  input  wire logic [BYTE_W-1:0]    data_byte,
  input  wire logic                 end_of_message,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [BYTE_W-1:0]    out_byte,
  output logic                      out_last,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [KEY_REG_W-1:0] cfg_data
);

  localparam int KidxW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  ctrl_t ctrl;
  cond_t cond;

  logic [KEY_REG_W-1:0] key_low;
  logic [KEY_REG_W-1:0] key_high;
  logic [KEY_SLOTS-1:0][BYTE_W-1:0] key_all;
  logic [KidxW-1:0] kidx;
  logic [BYTE_W-1:0] key_b;

  logic [BYTE_W-1:0] n;
  logic [BYTE_W-1:0] i;
  logic [BYTE_W-1:0] j;
  logic [BYTE_W-1:0] t;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] data_r;
  logic              eom_r;

  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] i_inc;
  logic [BYTE_W-1:0] j_sum;
  logic [BYTE_W-1:0] ks_addr;
  logic [BYTE_W-1:0] ks;
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] raddr;

  assign key_all = {key_high, key_low};
  assign key_b   = key_all[KEY_SLOT_W'(kidx)];

  assign i_inc   = i + 1'b1;
  assign j_sum   = j + rdata + (ctrl.cw.key_en ? key_b : '0);
  assign ks_addr = t + sj;

  // forward the swap writes that the RAM read did not see
  always_comb begin
    if (ks_addr == j) begin
      ks = t;
    end else if (ks_addr == i) begin
      ks = sj;
    end else begin
      ks = rdata;
    end
  end

  assign cond.in_valid = in_valid;
  assign cond.action   = action;
  assign cond.n_last   = (n == '1);
  assign cond.out_free = !out_valid || out_ready;

  assign in_ready = (ctrl.cw.op == OP_DISPATCH);

  rc4_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl)
  );

  always_comb begin
    raddr = n;
    case (ctrl.cw.ra)
      RA_N:     raddr = n;
      RA_I_INC: raddr = i_inc;
      RA_J_SUM: raddr = j_sum;
      RA_KS:    raddr = t + rdata;
      default:  raddr = n;
    endcase
  end

  always_comb begin
    waddr = n;
    case (ctrl.cw.wa)
      WA_N:    waddr = n;
      WA_I:    waddr = i;
      WA_J:    waddr = j;
      default: waddr = n;
    endcase
  end

  always_comb begin
    wdata = n;
    case (ctrl.cw.wd)
      WD_N:    wdata = n;
      WD_RD:   wdata = rdata;
      WD_T:    wdata = t;
      default: wdata = n;
    endcase
  end

  assign ram_we = (ctrl.cw.wa != WA_NONE);
  assign ram_re = (ctrl.cw.ra != RA_NONE);

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      kidx      <= '0;
      n         <= '0;
      i         <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_HIGH) begin
          key_high <= cfg_data;
        end else begin
          key_low <= cfg_data;
        end
      end
      if (ctrl.cw.clr_k) begin
        kidx <= '0;
      end else if (ctrl.cw.key_en) begin
        kidx <= (kidx == KidxW'(KEY_BYTES - 1)) ? '0 : kidx + 1'b1;
      end
      if (ctrl.cw.n_inc) begin
        n <= n + 1'b1;
      end
      if (ctrl.cw.clr_ij || (ctrl.emit && eom_r)) begin
        i <= '0;
        j <= '0;
      end else begin
        if (ctrl.cw.ld_i) begin
          i <= i_inc;
        end
        if (ctrl.cw.ld_j) begin
          j <= j_sum;
        end
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      data_r <= data_byte;
      eom_r  <= end_of_message;
    end
    if (ctrl.cw.ld_t) begin
      t <= rdata;
    end
    if (ctrl.cw.ld_sj) begin
      sj <= rdata;
    end
    if (ctrl.emit) begin
      out_byte <= data_r ^ ks;
      out_last <= eom_r;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> (!out_valid || out_ready))
    else $error("result beat overwrote a pending result");

  a_kidx_range: assert property (@(posedge clk) disable iff (rst)
    kidx <= KidxW'(KEY_BYTES - 1))
    else $error("key byte index out of range");

  a_clear_indices: assert property (@(posedge clk) disable iff (rst)
    ctrl.cw.clr_ij |=> (i == '0 && j == '0))
    else $error("indices not cleared");

  a_idle_n_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.accept |-> (n == '0))
    else $error("fill counter not at zero on a new beat");

endmodule

`default_nettype wire

>>> rtl/core/rc4_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rc4_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on rc4_pkg for the control word, step addresses and condition bundle.
`timescale 1ns / 1ps
`default_nettype none

module rc4_seq
  import rc4_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cond_t cond,
  output ctrl_t      ctrl
);

  step_t step;
  step_t step_next;
  ucw_t  cw;

  assign cw          = ucode_rom(step);
  assign ctrl.cw     = cw;
  assign ctrl.accept = (cw.op == OP_DISPATCH) && cond.in_valid;
  assign ctrl.emit   = (cw.op == OP_EMIT) && cond.out_free;

  always_comb begin
    step_next = step;
    case (cw.op)
      OP_NEXT: step_next = step + 1'b1;
      OP_DISPATCH: begin
        if (cond.in_valid) begin
          step_next = cond.action ? ST_CR0 : ST_FILL;
        end
      end
      OP_LOOP: step_next = cond.n_last ? step + 1'b1 : cw.target;
      OP_EMIT: begin
        if (cond.out_free) begin
          step_next = cw.target;
        end
      end
      OP_GOTO: step_next = cw.target;
      default: step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  a_rekey_to_fill: assert property (@(posedge clk) disable iff (rst)
    (ctrl.accept && !cond.action) |=> (step == ST_FILL))
    else $error("rekey beat did not start the fill");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (step == ST_IDLE && !cond.in_valid) |=> (step == ST_IDLE))
    else $error("sequencer left idle without a beat");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> (step == ST_IDLE))
    else $error("sequencer did not return to idle after a result beat");

endmodule

`default_nettype wire
